[rtl/core/sida_pkg.sv]
// Package: types and constants shared by the integer-to-decimal text converter.
`timescale 1ns / 1ps
package sida_pkg;

   localparam int VALUE_WIDTH   = 32;
   localparam int NUM_DIGITS    = 10;
   localparam int BIT_CNT_WIDTH = 5;
   localparam int COUNT_WIDTH   = 4;
   localparam int CHAR_WIDTH    = 7;
   localparam int DIGIT_WIDTH   = 4;

   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 7'd48;
   localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 7'd45;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_CONVERT,
      CELL_SHIFT
   } cell_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_ALIGN,
      ST_SIGN,
      ST_EMIT
   } state_type;

endpackage

[rtl/core/sida_cell.sv]
// One decimal digit cell of the conversion chain: shift-add-3, digit shift, clear or hold.
`timescale 1ns / 1ps
module sida_cell (
   input  logic                              clock,
   input  sida_pkg::cell_mode_type           mode,
   input  logic                              carry_in,
   input  logic [sida_pkg::DIGIT_WIDTH-1:0]  prev_digit,
   output logic                              carry_out,
   output logic [sida_pkg::DIGIT_WIDTH-1:0]  digit
);
   import sida_pkg::*;

   logic [DIGIT_WIDTH-1:0] digit_ff;
   logic [DIGIT_WIDTH-1:0] digit_in;
   logic [DIGIT_WIDTH-1:0] adjusted;

   always_comb begin
      adjusted = (digit_ff >= 4'd5) ? (digit_ff + 4'd3) : digit_ff;
      case (mode)
         CELL_CLEAR:   digit_in = '0;
         CELL_CONVERT: digit_in = {adjusted[DIGIT_WIDTH-2:0], carry_in};
         CELL_SHIFT:   digit_in = prev_digit;
         default:      digit_in = digit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign carry_out = adjusted[DIGIT_WIDTH-1];
   assign digit     = digit_ff;

endmodule

[rtl/core/signed_int_to_decimal_ascii.sv]
// Top level: signed 32-bit integer to decimal ASCII text, one character per strobe.
//
//   channel | ports                                          | handshake
//   --------+------------------------------------------------+---------------------------
//   request | req_value                                      | start & !busy
//   result  | rsp_character, rsp_text_length, rsp_last       | rsp_valid, one cycle each
//
// After acceptance the magnitude is shifted bit by bit through the ten-cell digit
// chain, up to nine leading zero digits are dropped and the length is latched, then
// one character leaves per cycle.
// Characters follow back to back, sign first; busy stays high until the last one.
// The receiver cannot stall. Reset (synchronous) returns the controller to idle.
`timescale 1ns / 1ps
module signed_int_to_decimal_ascii (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [sida_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                rsp_valid,
   output logic [sida_pkg::CHAR_WIDTH-1:0]     rsp_character,
   output logic [sida_pkg::COUNT_WIDTH-1:0]    rsp_text_length,
   output logic                                rsp_last
);
   import sida_pkg::*;

   localparam logic [BIT_CNT_WIDTH-1:0] BIT_LAST   = BIT_CNT_WIDTH'(VALUE_WIDTH - 1);
   localparam logic [COUNT_WIDTH-1:0]   SLOTS_FULL = COUNT_WIDTH'(NUM_DIGITS);

   state_type                  state_ff, state_in;
   logic [VALUE_WIDTH-1:0]     mag_ff, mag_in;
   logic [BIT_CNT_WIDTH-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [COUNT_WIDTH-1:0]     slot_cnt_ff, slot_cnt_in;
   logic [COUNT_WIDTH-1:0]     len_ff, len_in;
   logic                       neg_ff, neg_in;

   cell_mode_type              mode;
   logic                       accept;
   logic                       align_done;
   logic [VALUE_WIDTH-1:0]     raw;
   logic                       carry [NUM_DIGITS+1];
   logic [DIGIT_WIDTH-1:0]     prev  [NUM_DIGITS+1];
   logic [DIGIT_WIDTH-1:0]     top_digit;

   assign raw        = req_value;
   assign accept     = start && (state_ff == ST_IDLE);
   assign top_digit  = prev[NUM_DIGITS];
   assign align_done = (top_digit != '0) || (slot_cnt_ff == 4'd1);
   assign carry[0]   = mag_ff[VALUE_WIDTH-1];
   assign prev[0]    = '0;

   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_chain
      sida_cell u_cell (
         .clock      (clock),
         .mode       (mode),
         .carry_in   (carry[i]),
         .prev_digit (prev[i]),
         .carry_out  (carry[i+1]),
         .digit      (prev[i+1])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (start) state_in = ST_CONVERT;
         ST_CONVERT: if (bit_cnt_ff == BIT_LAST) state_in = ST_ALIGN;
         ST_ALIGN:   if (align_done) state_in = neg_ff ? ST_SIGN : ST_EMIT;
         ST_SIGN:    state_in = ST_EMIT;
         ST_EMIT:    if (slot_cnt_ff == 4'd1) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      mag_in      = mag_ff;
      bit_cnt_in  = bit_cnt_ff;
      slot_cnt_in = slot_cnt_ff;
      len_in      = len_ff;
      neg_in      = neg_ff;
      if (accept) begin
         neg_in      = raw[VALUE_WIDTH-1];
         mag_in      = raw[VALUE_WIDTH-1] ? (~raw + 32'd1) : raw;
         bit_cnt_in  = '0;
         slot_cnt_in = SLOTS_FULL;
      end else begin
         case (state_ff)
            ST_CONVERT: begin
               mag_in     = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
               bit_cnt_in = bit_cnt_ff + 5'd1;
            end
            ST_ALIGN: begin
               if (align_done) begin
                  len_in = slot_cnt_ff + {3'b000, neg_ff};
               end else begin
                  slot_cnt_in = slot_cnt_ff - 4'd1;
               end
            end
            ST_EMIT: slot_cnt_in = slot_cnt_ff - 4'd1;
            default: ;
         endcase
      end
   end

   // outputs
   always_comb begin
      mode            = CELL_HOLD;
      busy            = 1'b1;
      rsp_valid       = 1'b0;
      rsp_last        = 1'b0;
      rsp_character   = ASCII_ZERO + {3'b000, top_digit};
      rsp_text_length = len_ff;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) mode = CELL_CLEAR;
         end
         ST_CONVERT: mode = CELL_CONVERT;
         ST_ALIGN:   if (!align_done) mode = CELL_SHIFT;
         ST_SIGN: begin
            rsp_valid     = 1'b1;
            rsp_character = ASCII_MINUS;
         end
         ST_EMIT: begin
            mode      = CELL_SHIFT;
            rsp_valid = 1'b1;
            rsp_last  = (slot_cnt_ff == 4'd1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         bit_cnt_ff  <= '0;
         slot_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         bit_cnt_ff  <= bit_cnt_in;
         slot_cnt_ff <= slot_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      len_ff <= len_in;
      neg_ff <= neg_in;
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONVERT) |-> !carry[NUM_DIGITS])
      else $error("digit chain overflow during conversion");

   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !busy)
      else $error("busy after last character");

   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_character == ASCII_MINUS)) |-> !rsp_last)
      else $error("minus sign flagged as last character");

   a_start_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("request acceptance not followed by conversion");
`endif

endmodule

[test/sida_text_checker.sv]
// Checker: predicts the decimal text of every accepted request and compares each character.
`timescale 1ns / 1ps
module sida_text_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic                                    busy,
   input  logic signed [sida_pkg::VALUE_WIDTH-1:0] req_value,
   input  logic                                    rsp_valid,
   input  logic [sida_pkg::CHAR_WIDTH-1:0]         rsp_character,
   input  logic [sida_pkg::COUNT_WIDTH-1:0]        rsp_text_length,
   input  logic                                    rsp_last,
   output int                                      error_count,
   output int                                      pending_chars,
   output int                                      chars_checked,
   output logic [11:0]                             lengths_seen
);
   import sida_pkg::*;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0]  character;
      logic [COUNT_WIDTH-1:0] text_length;
      logic                   last;
   } text_char_type;

   text_char_type expected_chars [$];
   text_char_type oldest;

   initial begin
      error_count   = 0;
      pending_chars = 0;
      chars_checked = 0;
      lengths_seen  = '0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   function automatic void queue_text(input logic [VALUE_WIDTH-1:0] raw);
      logic                   negative;
      logic [VALUE_WIDTH-1:0] magnitude;
      logic [VALUE_WIDTH-1:0] remainder;
      logic [DIGIT_WIDTH-1:0] digits [NUM_DIGITS];
      int                     num_digits;
      int                     total;
      int                     pos;
      text_char_type          entry;
      negative   = raw[VALUE_WIDTH-1];
      magnitude  = negative ? (~raw + 1'b1) : raw;
      num_digits = 0;
      do begin
         remainder          = magnitude % 10;
         digits[num_digits] = remainder[DIGIT_WIDTH-1:0];
         magnitude          = magnitude / 10;
         num_digits++;
      end while (magnitude != 0 && num_digits < NUM_DIGITS);
      total = num_digits + (negative ? 1 : 0);
      pos   = 0;
      if (negative) begin
         entry.character   = ASCII_MINUS;
         entry.text_length = total[COUNT_WIDTH-1:0];
         entry.last        = (total == 1);
         expected_chars.push_back(entry);
         pos = 1;
      end
      for (int i = num_digits - 1; i >= 0; i--) begin
         entry.character   = ASCII_ZERO + digits[i];
         entry.text_length = total[COUNT_WIDTH-1:0];
         entry.last        = (pos == total - 1);
         expected_chars.push_back(entry);
         pos++;
      end
      lengths_seen[total] = 1'b1;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_chars.size() == 0) begin
               report_mismatch("character with no request pending", rsp_character, 0);
            end else begin
               oldest = expected_chars.pop_front();
               chars_checked++;
               if (rsp_character !== oldest.character)
                  report_mismatch("rsp_character", rsp_character, oldest.character);
               if (rsp_text_length !== oldest.text_length)
                  report_mismatch("rsp_text_length", rsp_text_length, oldest.text_length);
               if (rsp_last !== oldest.last)
                  report_mismatch("rsp_last", rsp_last, oldest.last);
            end
         end
         if (start && !busy) begin
            queue_text(req_value);
         end
      end
      pending_chars = expected_chars.size();
   end

endmodule

[test/tb_signed_int_to_decimal_ascii.sv]
// Testbench top: drives integer requests into the converter and reports the verdict.
`timescale 1ns / 1ps
module tb_signed_int_to_decimal_ascii;
   import sida_pkg::*;

   localparam logic [VALUE_WIDTH-1:0] DIRECTED [22] = '{
      32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
      -32'sd9, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd999999999,
      32'd1000000000, -32'sd999999999, -32'sd1000000000, 32'd123456789,
      -32'sd123456789, 32'd1999999999, 32'hFFFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA
   };

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic signed [VALUE_WIDTH-1:0] req_value = '0;
   logic                          busy;
   logic                          rsp_valid;
   logic [CHAR_WIDTH-1:0]         rsp_character;
   logic [COUNT_WIDTH-1:0]        rsp_text_length;
   logic                          rsp_last;
   int                            error_count;
   int                            pending_chars;
   int                            chars_checked;
   logic [11:0]                   lengths_seen;
   int                            requests_sent = 0;
   int                            negatives_sent = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   signed_int_to_decimal_ascii uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_character   (rsp_character),
      .rsp_text_length (rsp_text_length),
      .rsp_last        (rsp_last)
   );

   sida_text_checker text_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_character   (rsp_character),
      .rsp_text_length (rsp_text_length),
      .rsp_last        (rsp_last),
      .error_count     (error_count),
      .pending_chars   (pending_chars),
      .chars_checked   (chars_checked),
      .lengths_seen    (lengths_seen)
   );

   task automatic idle_cycles(input int count);
      repeat (count) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic send_request(input logic [VALUE_WIDTH-1:0] value);
      @(negedge clock);
      start     <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (busy);
      requests_sent++;
      if (value[VALUE_WIDTH-1])
         negatives_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_chars != 0)
         @(negedge clock);
   endtask

   function automatic logic [VALUE_WIDTH-1:0] random_value();
      longint                 lo;
      longint                 hi;
      longint                 magnitude;
      int                     num_digits;
      logic [VALUE_WIDTH-1:0] value;
      case ($urandom_range(0, 3))
         0: begin
            value = $urandom();
         end
         1: begin
            num_digits = $urandom_range(1, 10);
            lo = 1;
            repeat (num_digits - 1) lo = lo * 10;
            hi = lo * 10 - 1;
            if (hi > 64'd2147483648)
               hi = 64'd2147483648;
            if (num_digits == 1)
               lo = 0;
            magnitude = lo + $urandom_range(0, 32'(hi - lo));
            value = 32'(magnitude);
            if ($urandom_range(0, 1))
               value = ~value + 1'b1;
         end
         2: begin
            lo = 1;
            repeat ($urandom_range(0, 9)) lo = lo * 10;
            magnitude = lo + $urandom_range(0, 2) - 1;
            value = 32'(magnitude);
            if ($urandom_range(0, 1))
               value = ~value + 1'b1;
         end
         default: begin
            case ($urandom_range(0, 4))
               0: value = 32'h7FFF_FFFF;
               1: value = 32'h8000_0000;
               2: value = 32'h8000_0001;
               3: value = 32'h0000_0000;
               default: value = 32'($signed($urandom_range(0, 40)) - 20);
            endcase
         end
      endcase
      return value;
   endfunction

   task automatic random_phase(input int count, input int idle_percent);
      repeat (count) begin
         if ($urandom_range(0, 99) < idle_percent)
            idle_cycles($urandom_range(1, 50));
         send_request(random_value());
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i])
         send_request(DIRECTED[i]);
      wait_drained();

      random_phase(127, 8);
      wait_drained();
      random_phase(127, 51);
      wait_drained();
      random_phase(126, 0);
      wait_drained();
      repeat (60) @(posedge clock);

      $display("Converted %0d requests (%0d negative), %0d characters checked,",
               requests_sent, negatives_sent, chars_checked);
      $display("%0d of 11 text lengths produced.", $countones(lengths_seen));
      if (error_count == 0) begin
         $display("tb_signed_int_to_decimal_ascii: clean");
      end else begin
         $display("tb_signed_int_to_decimal_ascii: errors");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d characters still expected.", pending_chars);
      $display("tb_signed_int_to_decimal_ascii: errors");
      $finish;
   end

endmodule
